// ===== hw/rtl/pfbt_pkg.sv =====
// Shared types and constants for the peer flag blacklist table.
// Used by pfbt_match and peer_flag_blacklist_table; no dependencies.
package pfbt_pkg;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam int FUNC_W      = 2;
    localparam int ID_LOW_W    = 64;
    localparam int ID_MID_W    = 64;
    localparam int ID_HIGH_W   = 32;
    localparam int ID_W        = ID_LOW_W + ID_MID_W + ID_HIGH_W;
    localparam int MASK_W      = 8;
    localparam int FLAGS_OUT_W = 8;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((ID_W + MASK_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FLAGS_OUT_W + 2 + 7) / 8) * 8;
    localparam int S_TUSER_W = FUNC_W;

endpackage

// ===== hw/rtl/pfbt_match.sv =====
// Parallel key compare over all table entries, lowest free slot pick,
// and flag readout of the matching entry. Depends on pfbt_pkg.
module pfbt_match #(
    parameter int ENTRIES   = 16,
    parameter int FLAG_BITS = 8
) (
    input  logic [ENTRIES-1:0]          entry_valid,
    input  logic [pfbt_pkg::ID_W-1:0]   key_store [ENTRIES],
    input  logic [FLAG_BITS-1:0]        flag_store [ENTRIES],
    input  logic [pfbt_pkg::ID_W-1:0]   key,
    output logic [ENTRIES-1:0]          hit_vec,
    output logic [ENTRIES-1:0]          free_vec,
    output logic [FLAG_BITS-1:0]        hit_flags
);

    // keys are unique among valid entries, so hit_vec is one-hot or zero
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = entry_valid[i] && (key_store[i] == key);
        end
    end

    // lowest clear bit of entry_valid: ~v & (v + 1)
    assign free_vec = ~entry_valid & (entry_valid + ENTRIES'(1));

    always_comb
    begin
        hit_flags = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_flags = hit_flags | (flag_store[i] & {FLAG_BITS{hit_vec[i]}});
        end
    end

endmodule

// ===== hw/rtl/peer_flag_blacklist_table.sv =====
// Peer flag blacklist table: 160-bit identifier CAM with a flag word per entry.
// Pipeline: the request is registered in the input stage, and its result in the result stage.
// Throughput: one request per cycle while m_axis_tready holds; the table updates at the same edge that
// registers the result, so back-to-back requests see each other's effect.
// Reset: rst_n clears the valid bits (empty table) and both stream stages.
// Depends on pfbt_pkg and pfbt_match.
module peer_flag_blacklist_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int FLAG_BITS     = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: id_low[63:0], id_mid[127:64], id_high[159:128], flag_mask[167:160]
    input  logic [pfbt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: func[1:0]
    input  logic [pfbt_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: flags_now[7:0], was_present[8], table_full[9], zero pad[15:10]
    output logic [pfbt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);

    // input stage
    logic                             in_valid_reg;
    logic [pfbt_pkg::FUNC_W-1:0]      func_reg;
    logic [pfbt_pkg::ID_W-1:0]        id_reg;
    logic [pfbt_pkg::MASK_W-1:0]      mask_reg;

    // table
    logic [TABLE_ENTRIES-1:0]         valid_reg;
    logic [TABLE_ENTRIES-1:0]         valid_next;
    logic [pfbt_pkg::ID_W-1:0]        key_reg [TABLE_ENTRIES];
    logic [FLAG_BITS-1:0]             flags_reg [TABLE_ENTRIES];

    // result stage
    logic                             out_valid_reg;
    logic [pfbt_pkg::M_TDATA_W-1:0]   out_data_reg;
    logic [pfbt_pkg::M_TDATA_W-1:0]   out_data_next;

    logic                             s_accept;
    logic                             step;

    logic [TABLE_ENTRIES-1:0]         hit_vec;
    logic [TABLE_ENTRIES-1:0]         free_vec;
    logic [FLAG_BITS-1:0]             hit_flags;
    logic                             any_hit;
    logic                             any_free;

    pfbt_pkg::op_t                    op;
    logic [FLAG_BITS-1:0]             mask_ext;
    logic [FLAG_BITS-1:0]             new_flags;
    logic [FLAG_BITS-1:0]             flags_now;
    logic                             table_full;
    logic                             do_alloc;
    logic                             do_update;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            func_reg <= s_axis_tuser[pfbt_pkg::FUNC_W-1:0];
            id_reg   <= s_axis_tdata[pfbt_pkg::ID_W-1:0];
            mask_reg <= s_axis_tdata[pfbt_pkg::ID_W +: pfbt_pkg::MASK_W];
        end
    end

    pfbt_match #(
        .ENTRIES   (TABLE_ENTRIES),
        .FLAG_BITS (FLAG_BITS)
    ) u_match (
        .entry_valid (valid_reg),
        .key_store   (key_reg),
        .flag_store  (flags_reg),
        .key         (id_reg),
        .hit_vec     (hit_vec),
        .free_vec    (free_vec),
        .hit_flags   (hit_flags)
    );

    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;
    assign op       = pfbt_pkg::op_t'(func_reg);
    // mask bits above FLAG_BITS drop out here
    assign mask_ext = FLAG_BITS'(mask_reg);

    always_comb
    begin
        new_flags  = hit_flags;
        flags_now  = '0;
        table_full = 1'b0;
        do_alloc   = 1'b0;
        do_update  = 1'b0;
        valid_next = valid_reg;
        case (op)
            pfbt_pkg::OP_QUERY:
            begin
                flags_now = hit_flags;
            end
            pfbt_pkg::OP_ADD:
            begin
                if (any_hit)
                begin
                    new_flags = hit_flags | mask_ext;
                    do_update = 1'b1;
                    flags_now = new_flags;
                end
                else if (any_free)
                begin
                    // claimed even with an empty mask
                    do_alloc   = 1'b1;
                    valid_next = valid_reg | free_vec;
                    flags_now  = mask_ext;
                end
                else
                begin
                    table_full = 1'b1;
                end
            end
            pfbt_pkg::OP_DELETE:
            begin
                if (any_hit)
                begin
                    new_flags = hit_flags & ~mask_ext;
                    do_update = 1'b1;
                    flags_now = new_flags;
                    if (new_flags == '0)
                    begin
                        valid_next = valid_reg & ~hit_vec;
                    end
                end
            end
            pfbt_pkg::OP_CLEAR:
            begin
                valid_next = '0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_comb
    begin
        out_data_next                  = '0;
        out_data_next[pfbt_pkg::FLAGS_OUT_W-1:0] = pfbt_pkg::FLAGS_OUT_W'(flags_now);
        out_data_next[pfbt_pkg::FLAGS_OUT_W]     = any_hit;
        out_data_next[pfbt_pkg::FLAGS_OUT_W+1]   = table_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
        end
    end

    // key and flag words carry no reset; only valid entries are ever read
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (step && do_alloc && free_vec[i])
            begin
                key_reg[i]   <= id_reg;
                flags_reg[i] <= mask_ext;
            end
            else if (step && do_update && hit_vec[i])
            begin
                flags_reg[i] <= new_flags;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
